### rtl/core/gcd_lcm_prime_unit_assert.svh
// Assertion macros shared by the gcd/lcm/prime unit modules.
// Expects signals named clk and rst_n in the including module.
`ifndef GCD_LCM_PRIME_UNIT_ASSERT_SVH
`define GCD_LCM_PRIME_UNIT_ASSERT_SVH

// same-cycle implication
`define GCLP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication
`define GCLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### rtl/core/gclp_pkg.sv
// Shared types and constants for the gcd/lcm/prime unit.
// No dependencies; imported by controller, datapath and top level.
package gclp_pkg;

  localparam int GCLP_WIDTH = 32;

  typedef enum logic [1:0] {
    CMD_GCD     = 2'd0,
    CMD_LCM     = 2'd1,
    CMD_COPRIME = 2'd2,
    CMD_PRIME   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_OVF  = 2'd1,
    ERR_ZDIV = 2'd2
  } err_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        flag;
    logic [1:0]  error;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NOP       = 4'd0,
    OP_LOAD      = 4'd1,
    OP_DIV_INIT  = 4'd2,
    OP_DIV_STEP  = 4'd3,
    OP_EUC_NEXT  = 4'd4,
    OP_LCM_SETUP = 4'd5,
    OP_MUL_INIT  = 4'd6,
    OP_MUL_STEP  = 4'd7,
    OP_PRM_SETUP = 4'd8,
    OP_PRM_NEXT  = 4'd9
  } dp_op_t;

  typedef enum logic [2:0] {
    RES_GCD      = 3'd0,
    RES_COPRIME  = 3'd1,
    RES_LCM      = 3'd2,
    RES_LCM_ZDIV = 3'd3,
    RES_PRIME    = 3'd4,
    RES_NOTPRIME = 3'd5
  } res_kind_t;

  typedef struct packed {
    dp_op_t    op;
    logic      res_set;
    res_kind_t res_kind;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic x_zero;
    logic y_zero;
    logic cnt_last;
    logic a_lt2;
    logic a_lt4;
    logic a_even;
    logic d_gt_q;
    logic rem_zero;
  } dp_stat_t;

endpackage

### rtl/core/gclp_dpath.sv
// Datapath: operand registers, shared radix-2 divider, shift-add multiplier
// with overflow tracking, result and output registers. Uses gclp_pkg.
`include "gcd_lcm_prime_unit_assert.svh"

module gclp_dpath
  import gclp_pkg::*;
#(
  parameter int WIDTH = GCLP_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   dp_cmd,
  output dp_stat_t  dp_stat,
  output out_item_t out_data
);

  localparam int CW = $clog2(WIDTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

  cmd_t             cmd_r;
  logic [WIDTH-1:0] a_r, b_r, x_r, y_r;
  logic [WIDTH-1:0] rem_r, quo_r, acc_r;
  logic             ovf_r;
  logic [CW-1:0]    cnt_r;
  logic [WIDTH-1:0] res_value_r;
  logic             res_flag_r;
  err_t             res_err_r;
  out_item_t        out_data_r;

  logic [WIDTH:0]   div_t, div_sub;
  logic             div_ge;
  logic [WIDTH-1:0] div_rem;
  logic [WIDTH+1:0] mul_t;
  logic             mul_ovf;
  logic [WIDTH-1:0] a_in, b_in;

  assign a_in = WIDTH'(in_data.operand_a);
  assign b_in = WIDTH'(in_data.operand_b);

  // restoring division step: dividend bits shift out of quo_r from the top
  always_comb begin
    div_t   = {rem_r, quo_r[WIDTH-1]};
    div_ge  = div_t >= {1'b0, y_r};
    div_sub = div_t - {1'b0, y_r};
    div_rem = div_ge ? div_sub[WIDTH-1:0] : div_t[WIDTH-1:0];
  end

  // MSB-first multiply of quo_r by b_r; acc only grows, so overflow is sticky
  always_comb begin
    mul_t   = {1'b0, acc_r, 1'b0} + {2'b00, (quo_r[WIDTH-1] ? b_r : '0)};
    mul_ovf = ovf_r | (mul_t[WIDTH+1:WIDTH] != 2'b00);
  end

  always_ff @(posedge clk) begin
    case (dp_cmd.op)
      OP_LOAD: begin
        cmd_r <= in_data.cmd;
        a_r   <= a_in;
        b_r   <= b_in;
        x_r   <= a_in;
        y_r   <= b_in;
      end
      OP_DIV_INIT: begin
        rem_r <= '0;
        quo_r <= x_r;
        cnt_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= div_rem;
        quo_r <= {quo_r[WIDTH-2:0], div_ge};
        cnt_r <= cnt_r + 1'b1;
      end
      OP_EUC_NEXT: begin
        x_r <= y_r;
        y_r <= rem_r;
      end
      OP_LCM_SETUP: begin
        // x_r holds the gcd here; next divide a by it
        x_r   <= a_r;
        y_r   <= x_r;
        rem_r <= '0;
        quo_r <= a_r;
        cnt_r <= '0;
      end
      OP_MUL_INIT: begin
        acc_r <= '0;
        ovf_r <= 1'b0;
        cnt_r <= '0;
      end
      OP_MUL_STEP: begin
        acc_r <= mul_t[WIDTH-1:0];
        ovf_r <= mul_ovf;
        quo_r <= {quo_r[WIDTH-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
      end
      OP_PRM_SETUP: begin
        y_r   <= WIDTH'(3);
        rem_r <= '0;
        quo_r <= x_r;
        cnt_r <= '0;
      end
      OP_PRM_NEXT: begin
        y_r   <= y_r + WIDTH'(2);
        rem_r <= '0;
        quo_r <= x_r;
        cnt_r <= '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.res_set) begin
      case (dp_cmd.res_kind)
        RES_GCD: begin
          res_value_r <= x_r;
          res_flag_r  <= 1'b0;
          res_err_r   <= ERR_OK;
        end
        RES_COPRIME: begin
          res_value_r <= '0;
          res_flag_r  <= (x_r == WIDTH'(1));
          res_err_r   <= ERR_OK;
        end
        RES_LCM: begin
          // issued on the last multiply step, so take the step's results
          res_value_r <= mul_ovf ? '1 : mul_t[WIDTH-1:0];
          res_flag_r  <= 1'b0;
          res_err_r   <= mul_ovf ? ERR_OVF : ERR_OK;
        end
        RES_LCM_ZDIV: begin
          res_value_r <= '0;
          res_flag_r  <= 1'b0;
          res_err_r   <= ERR_ZDIV;
        end
        RES_PRIME: begin
          res_value_r <= '0;
          res_flag_r  <= 1'b1;
          res_err_r   <= ERR_OK;
        end
        default: begin
          res_value_r <= '0;
          res_flag_r  <= 1'b0;
          res_err_r   <= ERR_OK;
        end
      endcase
    end
    if (dp_cmd.out_load) begin
      out_data_r.value <= 32'(res_value_r);
      out_data_r.flag  <= res_flag_r;
      out_data_r.error <= res_err_r;
    end
  end

  assign out_data = out_data_r;

  always_comb begin
    dp_stat.cmd      = cmd_r;
    dp_stat.x_zero   = (x_r == '0);
    dp_stat.y_zero   = (y_r == '0);
    dp_stat.cnt_last = (cnt_r == CNT_LAST);
    dp_stat.a_lt2    = (a_r < WIDTH'(2));
    dp_stat.a_lt4    = (a_r < WIDTH'(4));
    dp_stat.a_even   = ~a_r[0];
    dp_stat.d_gt_q   = (y_r > quo_r);
    dp_stat.rem_zero = (rem_r == '0);
  end

  `GCLP_ASSERT_NOW(a_div_nonzero, dp_cmd.op == OP_DIV_STEP, y_r != '0)
  `GCLP_ASSERT_NOW(a_rem_bound, dp_cmd.op == OP_DIV_STEP, rem_r < y_r)
  `GCLP_ASSERT_NEXT(a_mul_clear, dp_cmd.op == OP_MUL_INIT, !ovf_r && acc_r == '0)

endmodule

### rtl/core/gclp_ctrl.sv
// Controller: sequences Euclid, lcm and trial-division steps on the datapath
// and owns the input stall and output valid. Uses gclp_pkg.
`include "gcd_lcm_prime_unit_assert.svh"

module gclp_ctrl
  import gclp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  cmd_t     in_cmd,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t dp_stat,
  output dp_cmd_t  dp_cmd
);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_EUC_CHK = 11'b000_0000_0010,
    ST_EUC_DIV = 11'b000_0000_0100,
    ST_EUC_NXT = 11'b000_0000_1000,
    ST_LCM_DIV = 11'b000_0001_0000,
    ST_MUL_INI = 11'b000_0010_0000,
    ST_MUL_RUN = 11'b000_0100_0000,
    ST_PRM_CHK = 11'b000_1000_0000,
    ST_PRM_DIV = 11'b001_0000_0000,
    ST_PRM_TST = 11'b010_0000_0000,
    ST_FIN     = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt       = state_r;
    dp_cmd.op       = OP_NOP;
    dp_cmd.res_set  = 1'b0;
    dp_cmd.res_kind = RES_GCD;
    dp_cmd.out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          dp_cmd.op = OP_LOAD;
          state_nxt = (in_cmd == CMD_PRIME) ? ST_PRM_CHK : ST_EUC_CHK;
        end
      end
      ST_EUC_CHK: begin
        if (dp_stat.y_zero) begin
          // Euclid done, gcd sits in x
          case (dp_stat.cmd)
            CMD_COPRIME: begin
              dp_cmd.res_set  = 1'b1;
              dp_cmd.res_kind = RES_COPRIME;
              state_nxt       = ST_FIN;
            end
            CMD_LCM: begin
              if (dp_stat.x_zero) begin
                dp_cmd.res_set  = 1'b1;
                dp_cmd.res_kind = RES_LCM_ZDIV;
                state_nxt       = ST_FIN;
              end else begin
                dp_cmd.op = OP_LCM_SETUP;
                state_nxt = ST_LCM_DIV;
              end
            end
            default: begin
              dp_cmd.res_set  = 1'b1;
              dp_cmd.res_kind = RES_GCD;
              state_nxt       = ST_FIN;
            end
          endcase
        end else begin
          dp_cmd.op = OP_DIV_INIT;
          state_nxt = ST_EUC_DIV;
        end
      end
      ST_EUC_DIV: begin
        dp_cmd.op = OP_DIV_STEP;
        if (dp_stat.cnt_last) state_nxt = ST_EUC_NXT;
      end
      ST_EUC_NXT: begin
        dp_cmd.op = OP_EUC_NEXT;
        state_nxt = ST_EUC_CHK;
      end
      ST_LCM_DIV: begin
        dp_cmd.op = OP_DIV_STEP;
        if (dp_stat.cnt_last) state_nxt = ST_MUL_INI;
      end
      ST_MUL_INI: begin
        dp_cmd.op = OP_MUL_INIT;
        state_nxt = ST_MUL_RUN;
      end
      ST_MUL_RUN: begin
        dp_cmd.op = OP_MUL_STEP;
        if (dp_stat.cnt_last) begin
          dp_cmd.res_set  = 1'b1;
          dp_cmd.res_kind = RES_LCM;
          state_nxt       = ST_FIN;
        end
      end
      ST_PRM_CHK: begin
        if (dp_stat.a_lt2) begin
          dp_cmd.res_set  = 1'b1;
          dp_cmd.res_kind = RES_NOTPRIME;
          state_nxt       = ST_FIN;
        end else if (dp_stat.a_lt4) begin
          dp_cmd.res_set  = 1'b1;
          dp_cmd.res_kind = RES_PRIME;
          state_nxt       = ST_FIN;
        end else if (dp_stat.a_even) begin
          dp_cmd.res_set  = 1'b1;
          dp_cmd.res_kind = RES_NOTPRIME;
          state_nxt       = ST_FIN;
        end else begin
          dp_cmd.op = OP_PRM_SETUP;
          state_nxt = ST_PRM_DIV;
        end
      end
      ST_PRM_DIV: begin
        dp_cmd.op = OP_DIV_STEP;
        if (dp_stat.cnt_last) state_nxt = ST_PRM_TST;
      end
      ST_PRM_TST: begin
        // divisor past the quotient means it passed the square root
        if (dp_stat.d_gt_q) begin
          dp_cmd.res_set  = 1'b1;
          dp_cmd.res_kind = RES_PRIME;
          state_nxt       = ST_FIN;
        end else if (dp_stat.rem_zero) begin
          dp_cmd.res_set  = 1'b1;
          dp_cmd.res_kind = RES_NOTPRIME;
          state_nxt       = ST_FIN;
        end else begin
          dp_cmd.op = OP_PRM_NEXT;
          state_nxt = ST_PRM_DIV;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          dp_cmd.out_load = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (dp_cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  `GCLP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `GCLP_ASSERT_NEXT(a_res_then_fin, dp_cmd.res_set, state_r == ST_FIN)
  `GCLP_ASSERT_NEXT(a_fin_exit, state_r == ST_FIN, state_r == ST_FIN || state_r == ST_IDLE)

endmodule

### rtl/core/gcd_lcm_prime_unit.sv
// Number-theory unit on unsigned magnitudes: gcd, lcm, coprime and prime tests.
// Channels: in_valid/in_stall/in_data carry an item {cmd, operand_a, operand_b};
// out_valid/out_stall/out_data return one item {value, flag, error} per input.
// One item is processed at a time; in_stall is high from acceptance until the
// result has moved into the output register. A result waiting under out_stall
// does not block the next input item from being accepted and worked on.
// All work runs on one radix-2 divider and a one-bit-per-cycle multiplier.
//   gcd / coprime: each Euclid remainder step is a check, a full division and
//     a swap of x and y; at most about 1.44*WIDTH steps.
//   lcm: Euclid, then one division and one multiply.
//   prime: one division per odd trial divisor from 3 up to sqrt(a); about
//     2^(WIDTH/2-1) divisors in the worst case.
// Values below 4 or even values finish without any division.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// out_valid; no clearing pass is needed. A stalled result holds its value.
module gcd_lcm_prime_unit
  import gclp_pkg::*;
#(
  parameter int WIDTH = GCLP_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  gclp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  gclp_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat),
    .out_data (out_data)
  );

endmodule
